>>> hw/rtl/tbaq_pkg.sv
// ----------------------------------------------------------------------------
// tbaq_pkg: shared types and constants for the token bucket admission queue
// Command and status codes, register map, reset values, controller state
// and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package tbaq_pkg;

	// Default parameter values
	localparam int QUEUE_DEPTH_DEF   = 64;
	localparam int FRACTION_BITS_DEF = 8;

	// Field and bus widths
	localparam int CFG_W     = 24;
	localparam int SIZE_W    = 16;
	localparam int FLOW_W    = 8;
	localparam int AMOUNT_W  = 32;
	localparam int PKTS_W    = 7;
	localparam int SLOT_W    = SIZE_W + FLOW_W;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 80;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	// Register reset values
	localparam logic [CFG_W-1:0] MAX_BUFFER_RST   = 24'd65536;
	localparam logic [CFG_W-1:0] BUCKET_DEPTH_RST = 24'd4096;

	// Register indexes (paddr[2])
	localparam logic REG_MAX_BUFFER   = 1'b0;
	localparam logic REG_BUCKET_DEPTH = 1'b1;

	typedef enum logic [1:0] {
		CMD_REFILL = 2'd0,
		CMD_OFFER  = 2'd1,
		CMD_TAKE   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_REFILLED = 3'd0,
		STAT_ACCEPTED = 3'd1,
		STAT_NO_ROOM  = 3'd2,
		STAT_NO_TOKEN = 3'd3,
		STAT_Q_FULL   = 3'd4,
		STAT_DEQUEUED = 3'd5,
		STAT_EMPTY    = 3'd6
	} stat_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;  // latch the incoming item
		logic commit;   // execute the latched item and load the result
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_full;  // result register holds a result not taken this cycle
	} dp_stat_t;

endpackage

>>> hw/rtl/token_bucket_admission_queue_top.sv
// ----------------------------------------------------------------------------
// token_bucket_admission_queue_top: packet queue guarded by a token bucket
// Each input item is first latched, then executed against the token level,
// occupancy and slot memory, whose read at the queue head is registered.
// The result is loaded into an output register at the first clock edge
// after the input transfer, or later while an earlier result still stalls
// there; the next item is taken while that result waits. The slot memory
// needs no clearing pass after reset. The user must write configuration over
// the APB port while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module token_bucket_admission_queue_top #(
	parameter int QUEUE_DEPTH   = tbaq_pkg::QUEUE_DEPTH_DEF,
	parameter int FRACTION_BITS = tbaq_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [15:0] packet_size, [23:16] flow_id, [55:24] refill_amount
	input  logic [tbaq_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] command
	input  logic [1:0]                    s_tuser,
	// Results
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [15:0] out_size, [23:16] out_flow, [47:24] tokens_left,
	// [71:48] occupancy, [78:72] packets_queued, [79] zero
	output logic [tbaq_pkg::M_TDATA_W-1:0] m_tdata,
	// [2:0] status
	output logic [2:0]                    m_tuser,
	// Configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tbaq_pkg::APB_AW-1:0]   paddr,
	input  logic [tbaq_pkg::APB_DW-1:0]   pwdata,
	output logic [tbaq_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	tbaq_pkg::dp_cmd_t          dp_cmd;
	tbaq_pkg::dp_stat_t         dp_stat;
	logic [tbaq_pkg::CFG_W-1:0] max_buffer;
	logic [tbaq_pkg::CFG_W-1:0] bucket_depth;

	tbaq_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.max_buffer  (max_buffer),
		.bucket_depth(bucket_depth)
	);

	tbaq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.dp_stat (dp_stat),
		.dp_cmd  (dp_cmd)
	);

	tbaq_dp #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.dp_stat     (dp_stat),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.max_buffer  (max_buffer),
		.bucket_depth(bucket_depth)
	);

endmodule

>>> hw/rtl/tbaq_ram.sv
// ----------------------------------------------------------------------------
// tbaq_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tbaq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/tbaq_regs.sv
// ----------------------------------------------------------------------------
// tbaq_regs: configuration register file
// APB-style slave holding the buffer limit and the bucket depth.
// ----------------------------------------------------------------------------
module tbaq_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tbaq_pkg::APB_AW-1:0]  paddr,
	input  logic [tbaq_pkg::APB_DW-1:0]  pwdata,
	output logic [tbaq_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output logic [tbaq_pkg::CFG_W-1:0]   max_buffer,
	output logic [tbaq_pkg::CFG_W-1:0]   bucket_depth
);

	logic [tbaq_pkg::CFG_W-1:0] max_buffer_q;
	logic [tbaq_pkg::CFG_W-1:0] bucket_depth_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_buffer_q   <= tbaq_pkg::MAX_BUFFER_RST;
			bucket_depth_q <= tbaq_pkg::BUCKET_DEPTH_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				tbaq_pkg::REG_MAX_BUFFER:   max_buffer_q   <= pwdata[tbaq_pkg::CFG_W-1:0];
				tbaq_pkg::REG_BUCKET_DEPTH: bucket_depth_q <= pwdata[tbaq_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			tbaq_pkg::REG_MAX_BUFFER:   prdata = tbaq_pkg::APB_DW'(max_buffer_q);
			tbaq_pkg::REG_BUCKET_DEPTH: prdata = tbaq_pkg::APB_DW'(bucket_depth_q);
			default:                    prdata = '0;
		endcase
	end

	assign max_buffer   = max_buffer_q;
	assign bucket_depth = bucket_depth_q;

endmodule

>>> hw/rtl/tbaq_ctrl.sv
// ----------------------------------------------------------------------------
// tbaq_ctrl: item sequencer
// Two-state controller: take an item, then execute it once the result
// register can accept the outcome.
// ----------------------------------------------------------------------------
module tbaq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  tbaq_pkg::dp_stat_t dp_stat,
	output tbaq_pkg::dp_cmd_t  dp_cmd
);

	tbaq_pkg::state_t state_q;
	tbaq_pkg::state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbaq_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			tbaq_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_next = tbaq_pkg::ST_EXEC;
				end
			end
			tbaq_pkg::ST_EXEC: begin
				if (!dp_stat.out_full) begin
					state_next = tbaq_pkg::ST_IDLE;
				end
			end
			default: state_next = tbaq_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready       = 1'b0;
		dp_cmd.capture = 1'b0;
		dp_cmd.commit  = 1'b0;
		unique case (state_q)
			tbaq_pkg::ST_IDLE: begin
				s_tready       = 1'b1;
				dp_cmd.capture = s_tvalid;
			end
			tbaq_pkg::ST_EXEC: begin
				dp_cmd.commit = !dp_stat.out_full;
			end
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/tbaq_dp.sv
// ----------------------------------------------------------------------------
// tbaq_dp: admission datapath
// Token level, occupancy, queue pointers, slot memory and result register.
// ----------------------------------------------------------------------------
module tbaq_dp #(
	parameter int QUEUE_DEPTH   = tbaq_pkg::QUEUE_DEPTH_DEF,
	parameter int FRACTION_BITS = tbaq_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tbaq_pkg::dp_cmd_t             dp_cmd,
	output tbaq_pkg::dp_stat_t            dp_stat,
	input  logic [tbaq_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tbaq_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [2:0]                    m_tuser,
	input  logic [tbaq_pkg::CFG_W-1:0]    max_buffer,
	input  logic [tbaq_pkg::CFG_W-1:0]    bucket_depth
);

	localparam int TOK_W = tbaq_pkg::CFG_W + FRACTION_BITS;
	localparam int SUM_W = ((TOK_W > tbaq_pkg::AMOUNT_W) ? TOK_W : tbaq_pkg::AMOUNT_W) + 1;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int OCC_W = tbaq_pkg::CFG_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [TOK_W-1:0] LEVEL_RST = TOK_W'(tbaq_pkg::BUCKET_DEPTH_RST) << FRACTION_BITS;

	// Latched item
	tbaq_pkg::cmd_t                item_cmd_q;
	logic [tbaq_pkg::SIZE_W-1:0]   item_size_q;
	logic [tbaq_pkg::FLOW_W-1:0]   item_flow_q;
	logic [tbaq_pkg::AMOUNT_W-1:0] item_amount_q;

	// Architectural state
	logic [TOK_W-1:0]          level_q;
	logic [tbaq_pkg::CFG_W-1:0] used_q;
	logic [CNT_W-1:0]          count_q;
	logic [IDX_W-1:0]          head_q;
	logic [IDX_W-1:0]          tail_q;

	// Result register
	logic                        out_valid_q;
	tbaq_pkg::stat_t             out_stat_q;
	logic [tbaq_pkg::SIZE_W-1:0] out_size_q;
	logic [tbaq_pkg::FLOW_W-1:0] out_flow_q;
	logic [tbaq_pkg::CFG_W-1:0]  out_tokens_q;
	logic [tbaq_pkg::CFG_W-1:0]  out_occ_q;
	logic [tbaq_pkg::PKTS_W-1:0] out_pkts_q;

	// Next values
	logic [SUM_W-1:0]           depth_fix;
	logic [SUM_W-1:0]           refill_sum;
	logic [OCC_W-1:0]           room_sum;
	logic                       no_room;
	logic                       no_tokens;
	logic                       q_full;
	logic                       q_empty;
	logic [tbaq_pkg::SLOT_W-1:0] rd_data;
	logic [tbaq_pkg::SIZE_W-1:0] deq_size;
	logic [tbaq_pkg::FLOW_W-1:0] deq_flow;
	logic                       push;
	logic                       pop;
	tbaq_pkg::stat_t            stat_n;
	logic [TOK_W-1:0]           level_n;
	logic [tbaq_pkg::CFG_W-1:0] used_n;
	logic [CNT_W-1:0]           count_n;
	logic [tbaq_pkg::SIZE_W-1:0] osize_n;
	logic [tbaq_pkg::FLOW_W-1:0] oflow_n;

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			item_cmd_q    <= tbaq_pkg::cmd_t'(s_tuser);
			item_size_q   <= s_tdata[15:0];
			item_flow_q   <= s_tdata[23:16];
			item_amount_q <= s_tdata[55:24];
		end
	end

	// Slot memory: written at the tail, read continuously at the head
	tbaq_ram #(
		.WIDTH(tbaq_pkg::SLOT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (push),
		.waddr(tail_q),
		.wdata({item_flow_q, item_size_q}),
		.raddr(head_q),
		.rdata(rd_data)
	);

	assign deq_size = rd_data[tbaq_pkg::SIZE_W-1:0];
	assign deq_flow = rd_data[tbaq_pkg::SLOT_W-1:tbaq_pkg::SIZE_W];

	// Checks on the current state
	always_comb begin
		depth_fix  = SUM_W'(bucket_depth) << FRACTION_BITS;
		refill_sum = SUM_W'(level_q) + SUM_W'(item_amount_q);
		room_sum   = OCC_W'(used_q) + OCC_W'(item_size_q);
		no_room    = room_sum > OCC_W'(max_buffer);
		no_tokens  = level_q[FRACTION_BITS +: tbaq_pkg::CFG_W] < tbaq_pkg::CFG_W'(item_size_q);
		q_full     = count_q >= DEPTH_CNT;
		q_empty    = count_q == '0;
	end

	// Execute the latched command
	always_comb begin
		stat_n  = tbaq_pkg::STAT_REFILLED;
		level_n = level_q;
		used_n  = used_q;
		count_n = count_q;
		osize_n = '0;
		oflow_n = '0;
		push    = 1'b0;
		pop     = 1'b0;
		case (item_cmd_q)
			tbaq_pkg::CMD_REFILL: begin
				level_n = (refill_sum > depth_fix) ? TOK_W'(depth_fix) : TOK_W'(refill_sum);
			end
			tbaq_pkg::CMD_OFFER: begin
				if (no_room) begin
					stat_n = tbaq_pkg::STAT_NO_ROOM;
				end else if (no_tokens) begin
					stat_n = tbaq_pkg::STAT_NO_TOKEN;
				end else if (q_full) begin
					stat_n = tbaq_pkg::STAT_Q_FULL;
				end else begin
					stat_n  = tbaq_pkg::STAT_ACCEPTED;
					level_n = level_q - (TOK_W'(item_size_q) << FRACTION_BITS);
					used_n  = room_sum[tbaq_pkg::CFG_W-1:0];
					count_n = count_q + 1'b1;
					push    = dp_cmd.commit;
				end
			end
			tbaq_pkg::CMD_TAKE: begin
				if (q_empty) begin
					stat_n = tbaq_pkg::STAT_EMPTY;
				end else begin
					stat_n  = tbaq_pkg::STAT_DEQUEUED;
					osize_n = deq_size;
					oflow_n = deq_flow;
					used_n  = (used_q >= tbaq_pkg::CFG_W'(deq_size)) ?
					          used_q - tbaq_pkg::CFG_W'(deq_size) : '0;
					count_n = count_q - 1'b1;
					pop     = dp_cmd.commit;
				end
			end
			default: ;
		endcase
	end

	// Update state on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RST;
			used_q  <= '0;
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
		end else if (dp_cmd.commit) begin
			level_q <= level_n;
			used_q  <= used_n;
			count_q <= count_n;
			if (push) begin
				tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
			end
		end
	end

	// Result valid: set on commit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (dp_cmd.commit) begin
			out_stat_q   <= stat_n;
			out_size_q   <= osize_n;
			out_flow_q   <= oflow_n;
			out_tokens_q <= level_n[FRACTION_BITS +: tbaq_pkg::CFG_W];
			out_occ_q    <= used_n;
			out_pkts_q   <= tbaq_pkg::PKTS_W'(count_n);
		end
	end

	assign dp_stat.out_full = out_valid_q & ~m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = {1'b0, out_pkts_q, out_occ_q, out_tokens_q, out_flow_q, out_size_q};

endmodule

>>> hw/rtl/tbaq_checker.sv
// ----------------------------------------------------------------------------
// tbaq_checker: port-level checks for the admission queue
// Watches the stream ports and flags sequencing or result-coding errors.
// ----------------------------------------------------------------------------
module tbaq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tbaq_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [2:0]                    m_tuser
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// One item at a time: no input transfer right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// A transfer into a free result register gives a result right after the execute state
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (!m_tvalid || m_tready) |-> ##2 m_tvalid)
		else $error("missing result");

	// Status code stays within the defined set
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= 3'(tbaq_pkg::STAT_EMPTY))
		else $error("bad status code");

	// Only a dequeue reports a packet
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != tbaq_pkg::STAT_DEQUEUED) |-> m_tdata[23:0] == '0)
		else $error("packet fields set without dequeue");

endmodule

bind token_bucket_admission_queue_top tbaq_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

>>> test/tbaq_admission_checker.sv
// ----------------------------------------------------------------------------
// tbaq_admission_checker: result predictor and checker for the admission queue
// Watches the item, result and APB channels. Each accepted item runs through
// a local token bucket and packet queue model, and the result it produces is
// queued. Each accepted result is compared field by field with the oldest
// queued one. Reports the number of failures and of results still awaited.
// ----------------------------------------------------------------------------
module tbaq_admission_checker
	import tbaq_pkg::*;
#(
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [1:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic [2:0]           m_tuser,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	input  logic                 pready,
	output int                   outstanding,
	output int                   fail_count
);

	typedef struct {
		stat_t          status;
		logic [15:0]    size;
		logic [7:0]     flow;
		logic [23:0]    tokens;
		logic [23:0]    occupancy;
		logic [6:0]     packets;
	} admit_result_t;

	// Local copy of the limits and of the bucket and queue state
	logic [CFG_W-1:0] max_buffer_cfg;
	logic [CFG_W-1:0] bucket_depth_cfg;
	logic [39:0]      token_level;
	logic [23:0]      buffer_used;
	int               packet_count;
	int               head_idx;
	int               tail_idx;
	logic [15:0]      slot_size [QUEUE_DEPTH];
	logic [7:0]       slot_flow [QUEUE_DEPTH];

	admit_result_t expected_results[$];
	admit_result_t want;
	int            errors;

	initial begin
		outstanding = 0;
		fail_count  = 0;
		errors      = 0;
	end

	// Run one item through the bucket and queue, queue the result it yields
	task automatic admit_predict(input logic [1:0] cmd, input logic [15:0] size,
			input logic [7:0] flow, input logic [31:0] amount);
		admit_result_t r;
		logic [39:0]   cap;
		logic [39:0]   sum;
		r.status = STAT_REFILLED;
		r.size   = '0;
		r.flow   = '0;
		cap = 40'(bucket_depth_cfg) << FRACTION_BITS;
		case (cmd)
			CMD_REFILL: begin
				sum = token_level + 40'(amount);
				token_level = (sum > cap) ? cap : sum;
			end
			CMD_OFFER: begin
				// room first, then tokens, then a free slot
				if (25'(buffer_used) + 25'(size) > 25'(max_buffer_cfg)) begin
					r.status = STAT_NO_ROOM;
				end else if ((token_level >> FRACTION_BITS) < 40'(size)) begin
					r.status = STAT_NO_TOKEN;
				end else if (packet_count >= QUEUE_DEPTH) begin
					r.status = STAT_Q_FULL;
				end else begin
					token_level = token_level - (40'(size) << FRACTION_BITS);
					slot_size[tail_idx] = size;
					slot_flow[tail_idx] = flow;
					tail_idx = (tail_idx + 1 >= QUEUE_DEPTH) ? 0 : tail_idx + 1;
					buffer_used = buffer_used + 24'(size);
					packet_count++;
					r.status = STAT_ACCEPTED;
				end
			end
			CMD_TAKE: begin
				if (packet_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.size = slot_size[head_idx];
					r.flow = slot_flow[head_idx];
					head_idx = (head_idx + 1 >= QUEUE_DEPTH) ? 0 : head_idx + 1;
					buffer_used = (buffer_used >= 24'(r.size)) ?
						buffer_used - 24'(r.size) : '0;
					packet_count--;
					r.status = STAT_DEQUEUED;
				end
			end
			default: ;
		endcase
		r.tokens    = token_level[FRACTION_BITS +: 24];
		r.occupancy = buffer_used;
		r.packets   = 7'(packet_count);
		expected_results.push_back(r);
	endtask

	task automatic check_field(input string name, input longint unsigned exp_v,
			input longint unsigned got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// Track limits, compare results, predict for new items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_buffer_cfg   = MAX_BUFFER_RST;
			bucket_depth_cfg = BUCKET_DEPTH_RST;
			token_level      = 40'(BUCKET_DEPTH_RST) << FRACTION_BITS;
			buffer_used      = '0;
			packet_count     = 0;
			head_idx         = 0;
			tail_idx         = 0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_BUCKET_DEPTH)
					bucket_depth_cfg = pwdata[CFG_W-1:0];
				else
					max_buffer_cfg = pwdata[CFG_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got status %0d",
						$time, m_tuser);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, m_tuser);
					check_field("out_size", want.size, m_tdata[15:0]);
					check_field("out_flow", want.flow, m_tdata[23:16]);
					check_field("tokens_left", want.tokens, m_tdata[47:24]);
					check_field("occupancy", want.occupancy, m_tdata[71:48]);
					check_field("packets_queued", want.packets, m_tdata[78:72]);
				end
			end
			if (s_tvalid && s_tready)
				admit_predict(s_tuser, s_tdata[15:0], s_tdata[23:16], s_tdata[55:24]);
			outstanding <= expected_results.size();
			fail_count  <= errors;
		end
	end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the token bucket admission queue
// Drives a directed run over bucket and buffer corner cases, then random
// refill, offer and take traffic under a range of limit settings and idle
// patterns on both stream sides. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	import tbaq_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         IDLE_LIMIT = 4000;
	localparam int         NUM_SEGS   = 11;
	localparam int         SEG_ITEMS  = 50;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [1:0]           s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [2:0]           m_tuser;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [APB_AW-1:0]    paddr    = '0;
	logic [APB_DW-1:0]    pwdata   = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	int outstanding;
	int fail_count;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;

	// Limit settings per random segment: buffer limit, bucket depth
	logic [23:0] seg_max [NUM_SEGS] = '{24'd65536, 24'hFFFFFF, 24'hFFFFFF, 24'd2000,
		24'd0, 24'd1000, 24'hFFFFFF, 24'd500, 24'd65536, 24'hFFFFFF, 24'd300};
	logic [23:0] seg_depth [NUM_SEGS] = '{24'd4096, 24'hFFFFFF, 24'hFFFFFF, 24'd300,
		24'd0, 24'hFFFFFF, 24'd10, 24'd50, 24'd4096, 24'hFFFFFF, 24'd1};

	always #4 clk = ~clk;

	token_bucket_admission_queue_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	tbaq_admission_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	// Result side: stall at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Present one item, idling first at random, and hold it until the transfer
	task automatic send_item(input logic [1:0] cmd, input logic [15:0] size,
			input logic [7:0] flow, input logic [31:0] amount);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {amount, flow, size};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and wait until every result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Write both limit registers back to back
	task automatic program_limits(input logic [23:0] max_v, input logic [23:0] depth_v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_MAX_BUFFER, 2'b00};
		pwdata  <= {8'($urandom()), max_v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		paddr   <= {REG_BUCKET_DEPTH, 2'b00};
		pwdata  <= {8'($urandom()), depth_v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Random item with the given mix of offers and takes
	task automatic send_random(input int offer_pct, input int take_pct);
		int          roll;
		logic [1:0]  cmd;
		logic [15:0] size;
		logic [31:0] amount;
		roll = $urandom_range(0, 99);
		if (roll < offer_pct)
			cmd = CMD_OFFER;
		else if (roll < offer_pct + take_pct)
			cmd = CMD_TAKE;
		else if (roll < 97)
			cmd = CMD_REFILL;
		else
			cmd = CMD_UNUSED;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			size = 16'($urandom_range(0, 63));
		else if (roll < 85)
			size = 16'($urandom_range(0, 2000));
		else
			size = 16'($urandom_range(0, 65535));
		roll = $urandom_range(0, 99);
		if (roll < 40)
			amount = $urandom_range(0, 32'h7FFF);
		else if (roll < 70)
			amount = $urandom_range(0, 32'hFFFFF);
		else if (roll < 90)
			amount = $urandom();
		else
			amount = roll[0] ? 32'hFFFF_FFFF : 32'd0;
		send_item(cmd, size, 8'($urandom()), amount);
	endtask

	initial begin
		int offer_pct;
		int take_pct;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits: empty take, unused command, refill extremes, token debits
		send_item(CMD_TAKE, 16'd0, 8'd0, 32'd0);
		send_item(CMD_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
		send_item(CMD_REFILL, 16'd0, 8'd0, 32'd0);
		send_item(CMD_REFILL, 16'd0, 8'd0, 32'hFFFF_FFFF);
		send_item(CMD_OFFER, 16'd0, 8'd0, 32'd0);
		send_item(CMD_OFFER, 16'hFFFF, 8'hFF, 32'd0);
		send_item(CMD_OFFER, 16'd4096, 8'hAA, 32'd0);
		send_item(CMD_OFFER, 16'd1, 8'h01, 32'd0);
		send_item(CMD_REFILL, 16'd0, 8'd0, 32'h1FF);
		send_item(CMD_OFFER, 16'd1, 8'h55, 32'd0);
		send_item(CMD_OFFER, 16'd1, 8'h56, 32'd0);
		send_item(CMD_REFILL, 16'd0, 8'd0, 32'h1);
		send_item(CMD_OFFER, 16'd1, 8'h57, 32'd0);
		drain_results();

		// Bucket depth lowered to 100: an empty refill, two refused offers, queue drained by takes
		program_limits(24'h1FFF, 24'd100);
		send_item(CMD_REFILL, 16'd0, 8'd0, 32'd0);
		send_item(CMD_OFFER, 16'h2000, 8'h11, 32'd0);
		send_item(CMD_OFFER, 16'd101, 8'h22, 32'd0);
		repeat (4) send_item(CMD_TAKE, 16'd0, 8'd0, 32'd0);
		drain_results();

		// Zero limits: only empty packets fit
		program_limits(24'd0, 24'd0);
		send_item(CMD_OFFER, 16'd0, 8'h33, 32'd0);
		send_item(CMD_OFFER, 16'd1, 8'h44, 32'd0);
		send_item(CMD_REFILL, 16'd0, 8'd0, 32'hFFFF_FFFF);
		send_item(CMD_TAKE, 16'd0, 8'd0, 32'd0);
		send_item(CMD_TAKE, 16'd0, 8'd0, 32'd0);
		drain_results();

		// Random segments, each with its own limits, traffic mix and idle pattern
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			program_limits(seg_max[seg], seg_depth[seg]);
			case (seg % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
				1: begin send_idle_pct = 79; recv_stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct <= 79; end
				default: begin send_idle_pct = 35; recv_stall_pct <= 35; end
			endcase
			if (seg == 1 || seg == 2 || seg == 9) begin
				offer_pct = 75;
				take_pct  = 8;
			end else if (seg == 6 || seg == 10) begin
				offer_pct = 25;
				take_pct  = 55;
			end else begin
				offer_pct = 45;
				take_pct  = 30;
			end
			// fill segments start with a full bucket so the queue can fill up
			if (offer_pct == 75)
				send_item(CMD_REFILL, 16'd0, 8'd0, 32'hFFFF_FFFF);
			repeat (SEG_ITEMS) send_random(offer_pct, take_pct);
			drain_results();
		end

		recv_stall_pct <= 0;
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
